### src/particle_motion_update_core_defines.svh
// assertion macros for the particle motion update core
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef PARTICLE_MOTION_UPDATE_CORE_DEFINES_SVH
`define PARTICLE_MOTION_UPDATE_CORE_DEFINES_SVH

// checked only while out of reset
`define PMU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define PMU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/pmu_pkg.sv
// shared types, constants and tables of the particle motion update core
// no dependencies
`timescale 1ns / 1ps

package pmu_pkg;

  localparam int MaxParticles = 64;
  localparam int IdxW         = $clog2(MaxParticles);
  localparam int CountW       = IdxW + 1;
  localparam int FracBits     = 16;
  localparam int CordicSteps  = 24;
  localparam int IterW        = 6;
  localparam int CfgIdxW      = 3;

  // commands
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_RESTORE = 2'd2;

  // motion modes
  localparam logic [2:0] MODE_SPREAD   = 3'd0;
  localparam logic [2:0] MODE_DROP     = 3'd1;
  localparam logic [2:0] MODE_GIVEN    = 3'd2;
  localparam logic [2:0] MODE_RING_XYY = 3'd3;
  localparam logic [2:0] MODE_SIDE     = 3'd4;
  localparam logic [2:0] MODE_RING_XZ  = 3'd5;
  localparam logic [2:0] MODE_RING_XY  = 3'd6;
  localparam logic [2:0] MODE_TRAIL    = 3'd7;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_MODE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LOOP  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PIV_X = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PIV_Y = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PIV_Z = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_COUNT = 3'd5;

  // reciprocal of ten, exact for 32-bit values after a shift by 35
  localparam logic [31:0] Recip10    = 32'hCCCC_CCCD;
  localparam int          Recip10Sh  = 35;

  typedef struct packed {
    logic [1:0]         command;
    logic [IdxW-1:0]    slot;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_z;
    logic [30:0]        load_speed;
    logic [30:0]        load_life;
    logic [15:0]        time_delta;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        trail_limit;
  } pmu_in_t;

  typedef struct packed {
    logic [IdxW-1:0]    out_slot;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [30:0]        out_elapsed;
    logic               restarted;
    logic               last;
  } pmu_out_t;

  typedef struct packed {
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic [30:0]        speed;
    logic [30:0]        life;
    logic [30:0]        elapsed;
  } pmu_entry_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_TAKE, OP_RDIV, OP_READ, OP_RESTORE, OP_ROT_INIT, OP_ROT,
    OP_VEC, OP_SQ0, OP_SQ1, OP_SQ2, OP_SQ3, OP_ROOT_INIT, OP_ROOT, OP_DIV_INIT,
    OP_DIV, OP_MV0, OP_MV1, OP_MV2, OP_MV3, OP_FIN
  } pmu_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_RDIV, S_RS_RD, S_RS_WR, S_RD, S_ROTI, S_ROT, S_VEC, S_SQ0, S_SQ1,
    S_SQ2, S_SQ3, S_ROOTI, S_ROOT, S_DIVI, S_DIV, S_MV0, S_MV1, S_MV2, S_MV3, S_FIN
  } pmu_state_e;

  typedef struct packed {
    pmu_op_e          op;
    logic [IdxW-1:0]  idx;
    logic [IterW-1:0] iter;
    logic             last;
  } pmu_cmd_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              ring;
  } pmu_stat_t;

  // angle table in turns scaled by 2^32
  function automatic logic signed [31:0] turn_atan(input logic [4:0] k);
    logic signed [31:0] a;
    case (k)
      5'd0:    a = 32'sd536870912;
      5'd1:    a = 32'sd316933406;
      5'd2:    a = 32'sd167458907;
      5'd3:    a = 32'sd85004756;
      5'd4:    a = 32'sd42667331;
      5'd5:    a = 32'sd21354465;
      5'd6:    a = 32'sd10679838;
      5'd7:    a = 32'sd5340245;
      5'd8:    a = 32'sd2670163;
      5'd9:    a = 32'sd1335087;
      5'd10:   a = 32'sd667544;
      5'd11:   a = 32'sd333772;
      5'd12:   a = 32'sd166886;
      5'd13:   a = 32'sd83443;
      5'd14:   a = 32'sd41722;
      5'd15:   a = 32'sd20861;
      5'd16:   a = 32'sd10430;
      5'd17:   a = 32'sd5215;
      5'd18:   a = 32'sd2608;
      5'd19:   a = 32'sd1304;
      5'd20:   a = 32'sd652;
      5'd21:   a = 32'sd326;
      5'd22:   a = 32'sd163;
      5'd23:   a = 32'sd81;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

### src/pmu_ctrl.sv
// sequencer of the particle motion update core
// depends on pmu_pkg; drives the datapath through pmu_cmd_t
`timescale 1ns / 1ps

module pmu_ctrl import pmu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_command_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  pmu_stat_t  stat_i,
  output pmu_cmd_t   cmd_o
);

  localparam logic [IterW-1:0] RdivLast = IterW'(32);
  localparam logic [IterW-1:0] RotLast  = IterW'(CordicSteps - 1);
  localparam logic [IterW-1:0] RootLast = IterW'(31);
  localparam logic [IterW-1:0] DivLast  = IterW'(30);

  pmu_state_e       state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             oval_q, oval_d;
  logic             last;
  logic             fire;

  assign last = ({1'b0, idx_q} == (stat_i.count - CountW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      iter_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      iter_q  <= iter_d;
      oval_q  <= oval_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    iter_d     = iter_q + IterW'(1);
    in_ready_o = 1'b0;
    fire       = 1'b0;
    cmd_o.op   = OP_NOP;
    cmd_o.idx  = idx_q;
    cmd_o.iter = iter_q;
    cmd_o.last = last;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        idx_d      = '0;
        iter_d     = '0;
        if (in_valid_i) begin
          case (in_command_i)
            CMD_LOAD: cmd_o.op = OP_LOAD;
            CMD_TICK: begin
              cmd_o.op = OP_TAKE;
              if (stat_i.count != '0) state_d = S_RDIV;
            end
            CMD_RESTORE: begin
              if (stat_i.count != '0) state_d = S_RS_RD;
            end
            default: cmd_o.op = OP_NOP;
          endcase
        end
      end
      S_RDIV: begin
        cmd_o.op = OP_RDIV;
        if (iter_q == RdivLast) state_d = S_RD;
      end
      S_RS_RD: begin
        cmd_o.op = OP_READ;
        state_d  = S_RS_WR;
      end
      S_RS_WR: begin
        cmd_o.op = OP_RESTORE;
        idx_d    = idx_q + IdxW'(1);
        state_d  = last ? S_IDLE : S_RS_RD;
      end
      S_RD: begin
        cmd_o.op = OP_READ;
        state_d  = stat_i.ring ? S_ROTI : S_VEC;
      end
      S_ROTI: begin
        cmd_o.op = OP_ROT_INIT;
        iter_d   = '0;
        state_d  = S_ROT;
      end
      S_ROT: begin
        cmd_o.op = OP_ROT;
        if (iter_q == RotLast) state_d = S_VEC;
      end
      S_VEC: begin
        cmd_o.op = OP_VEC;
        state_d  = S_SQ0;
      end
      S_SQ0: begin
        cmd_o.op = OP_SQ0;
        state_d  = S_SQ1;
      end
      S_SQ1: begin
        cmd_o.op = OP_SQ1;
        state_d  = S_SQ2;
      end
      S_SQ2: begin
        cmd_o.op = OP_SQ2;
        state_d  = S_SQ3;
      end
      S_SQ3: begin
        cmd_o.op = OP_SQ3;
        state_d  = S_ROOTI;
      end
      S_ROOTI: begin
        cmd_o.op = OP_ROOT_INIT;
        iter_d   = '0;
        state_d  = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.op = OP_ROOT;
        if (iter_q == RootLast) state_d = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.op = OP_DIV_INIT;
        iter_d   = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        if (iter_q == DivLast) state_d = S_MV0;
      end
      S_MV0: begin
        cmd_o.op = OP_MV0;
        state_d  = S_MV1;
      end
      S_MV1: begin
        cmd_o.op = OP_MV1;
        state_d  = S_MV2;
      end
      S_MV2: begin
        cmd_o.op = OP_MV2;
        state_d  = S_MV3;
      end
      S_MV3: begin
        cmd_o.op = OP_MV3;
        state_d  = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!oval_q || out_ready_i) begin
          cmd_o.op = OP_FIN;
          fire     = 1'b1;
          idx_d    = idx_q + IdxW'(1);
          state_d  = last ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    oval_d = oval_q;
    if (out_ready_i) oval_d = 1'b0;
    if (fire)        oval_d = 1'b1;
  end

  assign out_valid_o = oval_q;

endmodule

### src/pmu_dpath.sv
// datapath of the particle motion update core: particle memory, config,
// shared multiplier, ring rotator, root and divide lanes; depends on pmu_pkg
`timescale 1ns / 1ps

module pmu_dpath import pmu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  pmu_in_t            in_data_i,
  input  pmu_cmd_t           cmd_i,
  output pmu_stat_t          stat_o,
  output pmu_out_t           out_data_o
);

  // config
  logic [2:0]         mode_q;
  logic               loop_q;
  logic signed [31:0] piv_x_q, piv_y_q, piv_z_q;
  logic [CountW-1:0]  count_q, n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SPREAD;
      loop_q  <= 1'b0;
      piv_x_q <= '0;
      piv_y_q <= '0;
      piv_z_q <= '0;
      count_q <= CountW'(MaxParticles);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:  mode_q  <= cfg_data_i[2:0];
        REG_LOOP:  loop_q  <= cfg_data_i[0];
        REG_PIV_X: piv_x_q <= cfg_data_i;
        REG_PIV_Y: piv_y_q <= cfg_data_i;
        REG_PIV_Z: piv_z_q <= cfg_data_i;
        REG_COUNT: count_q <= cfg_data_i[CountW-1:0];
        default:   ;
      endcase
    end
  end

  assign n_eff = (count_q > CountW'(MaxParticles)) ? CountW'(MaxParticles) : count_q;
  assign stat_o.count = n_eff;
  assign stat_o.ring  = (mode_q == MODE_RING_XYY) || (mode_q == MODE_RING_XZ) ||
                        (mode_q == MODE_RING_XY);

  // tick item fields
  logic [15:0]        dt_q;
  logic signed [31:0] dir_x_q, dir_y_q, dir_z_q;
  logic [30:0]        trail_q;

  // particle memory
  pmu_entry_t      mem_q [MaxParticles];
  pmu_entry_t      rd_q, wd;
  logic            we;
  logic [IdxW-1:0] wa;

  // ring phase
  logic [32:0]        rdq_q;
  logic [CountW-1:0]  rdr_q, prem_q;
  logic [31:0]        phase_q;
  logic [CountW:0]    rd_t, ps;
  logic               rd_ge, wrap;

  // rotator
  logic signed [31:0] cx_q, cy_q, cz_q, rdx, rdy;
  logic [1:0]         quad;

  // direction and magnitudes
  logic signed [33:0] v [3];
  logic [32:0]        mabs [3];
  logic [30:0]        m_q [3];
  logic               neg_q [3];
  logic               any32, any31;

  // multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, prod_q;
  logic [30:0] step_q;
  logic [63:0] acc_q;

  // root
  logic [63:0] sqn_q, root_q, bit_q, sq_t;

  // divide lanes
  logic [31:0] dv_rem_q [3];
  logic [30:0] dv_sh_q [3];
  logic [30:0] u_q [3];
  logic [32:0] dv_t [3];
  logic        dv_ge [3];
  logic [30:0] u_use [3];
  logic [30:0] mv_q [3];

  // final update
  logic signed [33:0] mvs [3];
  logic signed [33:0] drift, nx, ny, nz;
  logic signed [31:0] sx, sy, sz;
  logic [31:0]        el_sum;
  logic [30:0]        el_new, limit;
  logic               rs;
  pmu_out_t           out_q;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] a);
    logic signed [31:0] r;
    if (a > 34'sh0_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
    else if (a < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else                            r = a[31:0];
    return r;
  endfunction

  // memory ports
  always_comb begin
    we = 1'b0;
    wa = cmd_i.idx;
    wd = rd_q;
    case (cmd_i.op)
      OP_LOAD: begin
        we         = 1'b1;
        wa         = in_data_i.slot;
        wd.cur_x   = in_data_i.load_x;
        wd.cur_y   = in_data_i.load_y;
        wd.cur_z   = in_data_i.load_z;
        wd.start_x = in_data_i.load_x;
        wd.start_y = in_data_i.load_y;
        wd.start_z = in_data_i.load_z;
        wd.speed   = in_data_i.load_speed;
        wd.life    = in_data_i.load_life;
        wd.elapsed = '0;
      end
      OP_RESTORE: begin
        we         = 1'b1;
        wd.cur_x   = rd_q.start_x;
        wd.cur_y   = rd_q.start_y;
        wd.cur_z   = rd_q.start_z;
        wd.elapsed = '0;
      end
      OP_FIN: begin
        we         = 1'b1;
        wd.cur_x   = rs ? rd_q.start_x : sx;
        wd.cur_y   = rs ? rd_q.start_y : sy;
        wd.cur_z   = rs ? rd_q.start_z : sz;
        wd.elapsed = rs ? '0 : el_new;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    if (cmd_i.op == OP_READ) rd_q <= mem_q[cmd_i.idx];
  end

  // ring phase: 2^32 / n once per tick, then stepped per particle
  assign rd_t  = {rdr_q, (cmd_i.iter == '0)};
  assign rd_ge = rd_t >= {1'b0, n_eff};
  assign ps    = {1'b0, prem_q} + {1'b0, rdr_q};
  assign wrap  = ps >= {1'b0, n_eff};

  // rotator
  assign quad = phase_q[31:30];
  assign rdx  = cy_q >>> cmd_i.iter[4:0];
  assign rdy  = cx_q >>> cmd_i.iter[4:0];

  // direction per mode
  always_comb begin
    v[0] = '0;
    v[1] = '0;
    v[2] = '0;
    case (mode_q)
      MODE_SPREAD: begin
        v[0] = 34'(rd_q.cur_x) - 34'(piv_x_q);
        v[1] = 34'(rd_q.cur_y) - 34'(piv_y_q);
        v[2] = 34'(rd_q.cur_z) - 34'(piv_z_q);
      end
      MODE_DROP: v[1] = -34'sd1;
      MODE_SIDE: begin
        v[0] = 34'(rd_q.cur_x) - 34'(piv_x_q);
        v[1] = 34'(rd_q.cur_y) - 34'(piv_y_q);
      end
      MODE_RING_XYY: begin
        v[0] = 34'(cx_q);
        v[1] = 34'(cy_q);
        v[2] = 34'(cy_q);
      end
      MODE_RING_XZ: begin
        v[0] = 34'(cx_q);
        v[2] = 34'(cy_q);
      end
      MODE_RING_XY: begin
        v[0] = 34'(cx_q);
        v[1] = 34'(cy_q);
      end
      default: begin
        v[0] = 34'(dir_x_q);
        v[1] = 34'(dir_y_q);
        v[2] = 34'(dir_z_q);
      end
    endcase
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [33:0] vn;
    assign vn       = -v[k];
    assign mabs[k]  = v[k][33] ? vn[32:0] : v[k][32:0];
    assign dv_t[k]  = {dv_rem_q[k], dv_sh_q[k][30]};
    assign dv_ge[k] = dv_t[k] >= {1'b0, root_q[31:0]};
    assign u_use[k] = (root_q[31:0] == '0) ? '0 : u_q[k];
    assign mvs[k]   = neg_q[k] ? -34'(mv_q[k]) : 34'(mv_q[k]);

    always_ff @(posedge clk_i) begin
      case (cmd_i.op)
        OP_VEC: begin
          neg_q[k] <= v[k][33];
          m_q[k]   <= any32 ? mabs[k][32:2] : (any31 ? mabs[k][31:1] : mabs[k][30:0]);
        end
        OP_DIV_INIT: begin
          dv_rem_q[k] <= {2'b0, m_q[k][30:1]};
          dv_sh_q[k]  <= {m_q[k][0], 30'b0};
          u_q[k]      <= '0;
        end
        OP_DIV: begin
          dv_rem_q[k] <= dv_ge[k] ? 32'(dv_t[k] - {1'b0, root_q[31:0]}) : dv_t[k][31:0];
          dv_sh_q[k]  <= {dv_sh_q[k][29:0], 1'b0};
          u_q[k]      <= {u_q[k][29:0], dv_ge[k]};
        end
        default: ;
      endcase
    end
  end

  assign any32 = mabs[0][32] | mabs[1][32] | mabs[2][32];
  assign any31 = mabs[0][31] | mabs[1][31] | mabs[2][31];

  // shared multiplier, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_VEC: begin
        mul_a = {1'b0, rd_q.speed};
        mul_b = {16'b0, dt_q};
      end
      OP_SQ0: begin
        mul_a = {1'b0, m_q[0]};
        mul_b = {1'b0, m_q[0]};
      end
      OP_SQ1: begin
        mul_a = {1'b0, m_q[1]};
        mul_b = {1'b0, m_q[1]};
      end
      OP_SQ2: begin
        mul_a = {1'b0, m_q[2]};
        mul_b = {1'b0, m_q[2]};
      end
      OP_SQ3: begin
        mul_a = {1'b0, step_q};
        mul_b = Recip10;
      end
      OP_MV0: begin
        mul_a = {1'b0, u_use[0]};
        mul_b = {1'b0, step_q};
      end
      OP_MV1: begin
        mul_a = {1'b0, u_use[1]};
        mul_b = {1'b0, step_q};
      end
      OP_MV2: begin
        mul_a = {1'b0, u_use[2]};
        mul_b = {1'b0, step_q};
      end
      default: ;
    endcase
  end

  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};
  assign sq_t  = root_q + bit_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (cmd_i.op)
      OP_TAKE: begin
        dt_q    <= in_data_i.time_delta;
        dir_x_q <= in_data_i.dir_x;
        dir_y_q <= in_data_i.dir_y;
        dir_z_q <= in_data_i.dir_z;
        trail_q <= in_data_i.trail_limit;
        rdq_q   <= '0;
        rdr_q   <= '0;
        phase_q <= '0;
        prem_q  <= '0;
      end
      OP_RDIV: begin
        rdr_q <= rd_ge ? CountW'(rd_t - {1'b0, n_eff}) : rd_t[CountW-1:0];
        rdq_q <= {rdq_q[31:0], rd_ge};
      end
      OP_ROT_INIT: begin
        cx_q <= (quad == 2'd0) ? 32'sh2000_0000 : ((quad == 2'd2) ? -32'sh2000_0000 : '0);
        cy_q <= (quad == 2'd1) ? 32'sh2000_0000 : ((quad == 2'd3) ? -32'sh2000_0000 : '0);
        cz_q <= {2'b0, phase_q[29:0]};
      end
      OP_ROT: begin
        if (!cz_q[31]) begin
          cx_q <= cx_q - rdx;
          cy_q <= cy_q + rdy;
          cz_q <= cz_q - turn_atan(cmd_i.iter[4:0]);
        end else begin
          cx_q <= cx_q + rdx;
          cy_q <= cy_q - rdy;
          cz_q <= cz_q + turn_atan(cmd_i.iter[4:0]);
        end
      end
      OP_SQ0: step_q <= prod_q[FracBits+30:FracBits];
      OP_SQ1: acc_q  <= prod_q;
      OP_SQ2: acc_q  <= acc_q + prod_q;
      OP_SQ3: acc_q  <= acc_q + prod_q;
      OP_ROOT_INIT: begin
        if (mode_q == MODE_TRAIL) step_q <= {2'b0, prod_q[63:Recip10Sh]};
        sqn_q  <= acc_q;
        root_q <= '0;
        bit_q  <= 64'h4000_0000_0000_0000;
      end
      OP_ROOT: begin
        if (sqn_q >= sq_t) begin
          sqn_q  <= sqn_q - sq_t;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_MV1: mv_q[0] <= prod_q[60:30];
      OP_MV2: mv_q[1] <= prod_q[60:30];
      OP_MV3: mv_q[2] <= prod_q[60:30];
      OP_FIN: begin
        prem_q  <= wrap ? CountW'(ps - {1'b0, n_eff}) : ps[CountW-1:0];
        phase_q <= phase_q + rdq_q[31:0] + 32'(wrap);
        out_q.out_slot    <= cmd_i.idx;
        out_q.out_x       <= rs ? rd_q.start_x : sx;
        out_q.out_y       <= rs ? rd_q.start_y : sy;
        out_q.out_z       <= rs ? rd_q.start_z : sz;
        out_q.out_elapsed <= rs ? '0 : el_new;
        out_q.restarted   <= rs;
        out_q.last        <= cmd_i.last;
      end
      default: ;
    endcase
  end

  // new position and lifetime
  assign drift = (mode_q != MODE_SIDE) ? '0 :
                 (cmd_i.idx[0] ? 34'({3'b0, step_q[30:1]}) : -34'({3'b0, step_q[30:1]}));
  assign nx = 34'(rd_q.cur_x) + mvs[0] + drift;
  assign ny = 34'(rd_q.cur_y) + mvs[1];
  assign nz = 34'(rd_q.cur_z) + mvs[2];
  assign sx = sat32(nx);
  assign sy = sat32(ny);
  assign sz = sat32(nz);

  assign el_sum = {1'b0, rd_q.elapsed} + {16'b0, dt_q};
  assign el_new = (mode_q == MODE_GIVEN) ? rd_q.elapsed :
                  (el_sum[31] ? 31'h7FFF_FFFF : el_sum[30:0]);
  assign limit  = (mode_q == MODE_TRAIL) ? trail_q : rd_q.life;
  assign rs     = loop_q && (el_new >= limit);

  assign out_data_o = out_q;

endmodule

### src/particle_motion_update_core.sv
// particle motion update core: 64-entry particle table moved on each tick
// load: writes one entry; restore: reads and rewrites each particle in use
// tick: divides 2^32 by the particle count for the ring step, then moves each particle in turn
// (ring modes rotate first) through a 32-step root and 31-step divide on one shared multiplier
// reset clears config (count 64) and control; particle entries are undefined until loaded
`timescale 1ns / 1ps
`include "particle_motion_update_core_defines.svh"

module particle_motion_update_core import pmu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pmu_in_t            in_data_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pmu_out_t           out_data_o,
  // register writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  pmu_cmd_t  cmd;
  pmu_stat_t stat;

  // registers are always writable; writes must be made only while idle, which the user must ensure
  assign cfg_ready_o = 1'b1;

  // sequencer: walks the particles and steps the datapath
  pmu_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // datapath: table, config, arithmetic and result register
  pmu_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

  // a result is never written over one still waiting
  `PMU_ASSERT_ALWAYS(a_no_overwrite, (cmd.op == OP_FIN) |-> (!out_valid_o || out_ready_i), "result overwritten")

  // every finished particle shows up on the output next cycle
  `PMU_ASSERT(a_fin_shows, (cmd.op == OP_FIN) |=> out_valid_o, "finished particle not presented")

  // only particles in use are finished
  `PMU_ASSERT(a_idx_range, (cmd.op == OP_FIN) |-> ({1'b0, cmd.idx} < stat.count), "particle index out of range")

endmodule
